@@ src/lrt_pkg.sv @@
// ---------------------------------------------------------------------------
// LRU residency table package
// Shared types and codes for the table controller, datapath and top level.
// ---------------------------------------------------------------------------
package lrt_pkg;

    typedef enum logic [1:0] {
        MODE_ENSURE = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_LIMIT  = 2'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EVICT,
        ST_INSERT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_TOUCH,
        OP_EVICT,
        OP_INSERT
    } op_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_HIT,
        RES_NEW,
        RES_FREED
    } res_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
        res_t res_kind;
        logic res_success;
        logic res_last;
    } lrt_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  enable;
        logic  hit;
        logic  insert_ok;
        logic  over_limit;
        logic  any_valid;
        logic  last_evict;
    } lrt_stat_t;

endpackage

@@ src/lrt_datapath.sv @@
// ---------------------------------------------------------------------------
// LRU residency table datapath
// Entry storage, parallel key match, oldest-entry search and result register.
// ---------------------------------------------------------------------------
module lrt_datapath
    import lrt_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             in_mode,
    input  logic [KEY_BITS-1:0]    in_key,
    input  logic [14:0]            in_width,
    input  logic [14:0]            in_height,
    input  logic [2:0]             in_channels,
    input  logic [HANDLE_BITS-1:0] in_handle,
    input  logic                   enable,
    input  logic [4:0]             capacity_limit,
    input  lrt_cmd_t               cmd,
    output lrt_stat_t              stat,
    output logic                   res_success,
    output logic [HANDLE_BITS-1:0] res_handle,
    output logic                   res_freed_valid,
    output logic [HANDLE_BITS-1:0] res_freed_handle,
    output logic                   res_last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0]    key_reg [CAPACITY];
    logic [HANDLE_BITS-1:0] handle_reg [CAPACITY];
    logic [CAPACITY-1:0]    valid_reg;
    logic [IW-1:0]          rank_reg [CAPACITY];
    logic [CW-1:0]          count_reg;

    mode_t                  mode_reg;
    logic [KEY_BITS-1:0]    rkey_reg;
    logic [HANDLE_BITS-1:0] up_reg;
    logic                   dims_ok_reg;

    logic [CAPACITY-1:0] match;
    logic [IW-1:0]       hit_idx;
    logic [IW-1:0]       old_idx;
    logic [IW-1:0]       free_idx;
    logic                hit;
    logic                full;
    logic [CW-1:0]       lim;

    always_comb
    begin
        hit_idx  = '0;
        old_idx  = '0;
        free_idx = '0;
        hit      = 1'b0;
        full     = &valid_reg;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == rkey_reg);
            if (match[i])
            begin
                hit_idx = IW'(i);
                hit     = 1'b1;
            end
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
            if (valid_reg[i] && rank_reg[i] == IW'(count_reg - CW'(1)))
            begin
                old_idx = IW'(i);
            end
        end
        if (capacity_limit == 5'd0)
        begin
            lim = CW'(1);
        end
        else if (int'(capacity_limit) > CAPACITY)
        begin
            lim = CW'(CAPACITY);
        end
        else
        begin
            lim = CW'(capacity_limit);
        end
    end

    assign stat.mode       = mode_reg;
    assign stat.enable     = enable;
    assign stat.hit        = hit;
    assign stat.insert_ok  = dims_ok_reg && (up_reg != '0);
    assign stat.over_limit = (count_reg != '0) && ({1'b0, count_reg} >= {1'b0, lim});
    assign stat.any_valid  = |valid_reg;
    assign stat.last_evict = (mode_reg == MODE_CLEAR) ? (count_reg == CW'(1))
                                                      : (count_reg == lim);

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LATCH)
        begin
            mode_reg    <= mode_t'(in_mode);
            rkey_reg    <= in_key;
            up_reg      <= in_handle;
            dims_ok_reg <= (in_width != '0) && (in_height != '0) && (in_channels != '0);
        end
        if (cmd.op == OP_INSERT)
        begin
            key_reg[free_idx]    <= rkey_reg;
            handle_reg[free_idx] <= up_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_EVICT:
                begin
                    valid_reg[old_idx] <= 1'b0;
                    count_reg          <= count_reg - CW'(1);
                end
                OP_INSERT:
                begin
                    if (!full)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        count_reg           <= count_reg + CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (cmd.op == OP_TOUCH)
                begin
                    if (IW'(i) == hit_idx)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i] && rank_reg[i] < rank_reg[hit_idx])
                    begin
                        rank_reg[i] <= rank_reg[i] + IW'(1);
                    end
                end
                else if (cmd.op == OP_INSERT && !full)
                begin
                    if (IW'(i) == free_idx)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + IW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_success <= cmd.res_success;
            res_last    <= cmd.res_last;
            case (cmd.res_kind)
                RES_HIT:
                begin
                    res_handle       <= handle_reg[hit_idx];
                    res_freed_valid  <= 1'b0;
                    res_freed_handle <= '0;
                end
                RES_NEW:
                begin
                    res_handle       <= up_reg;
                    res_freed_valid  <= 1'b0;
                    res_freed_handle <= '0;
                end
                RES_FREED:
                begin
                    res_handle       <= (mode_reg == MODE_ENSURE) ? up_reg : '0;
                    res_freed_valid  <= 1'b1;
                    res_freed_handle <= handle_reg[old_idx];
                end
                default:
                begin
                    res_handle       <= '0;
                    res_freed_valid  <= 1'b0;
                    res_freed_handle <= '0;
                end
            endcase
        end
    end

endmodule

@@ src/lrt_control.sv @@
// ---------------------------------------------------------------------------
// LRU residency table controller
// Sequences one item through decision, evictions, insertion and result delivery.
// ---------------------------------------------------------------------------
module lrt_control
    import lrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_ready,
    input  lrt_stat_t stat,
    output logic      in_ready,
    output logic      out_valid,
    output lrt_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   ov_reg;
    logic   ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next      = state_reg;
        ov_next         = ov_reg && !out_ready;
        in_ready        = 1'b0;
        cmd.op          = OP_NONE;
        cmd.out_load    = 1'b0;
        cmd.res_kind    = RES_ZERO;
        cmd.res_success = 1'b0;
        cmd.res_last    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                    case (stat.mode)
                        MODE_ENSURE:
                        begin
                            if (!stat.enable)
                            begin
                                cmd.res_kind = RES_ZERO;
                            end
                            else if (stat.hit)
                            begin
                                cmd.op          = OP_TOUCH;
                                cmd.res_kind    = RES_HIT;
                                cmd.res_success = 1'b1;
                            end
                            else if (!stat.insert_ok)
                            begin
                                cmd.res_kind = RES_ZERO;
                            end
                            else if (stat.over_limit)
                            begin
                                cmd.op          = OP_EVICT;
                                cmd.res_kind    = RES_FREED;
                                cmd.res_success = 1'b1;
                                cmd.res_last    = stat.last_evict;
                                state_next      = stat.last_evict ? ST_INSERT : ST_EVICT;
                            end
                            else
                            begin
                                cmd.op          = OP_INSERT;
                                cmd.res_kind    = RES_NEW;
                                cmd.res_success = 1'b1;
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            cmd.res_kind    = stat.hit ? RES_HIT : RES_ZERO;
                            cmd.res_success = stat.hit;
                        end
                        MODE_CLEAR:
                        begin
                            if (stat.any_valid)
                            begin
                                cmd.op       = OP_EVICT;
                                cmd.res_kind = RES_FREED;
                                cmd.res_last = stat.last_evict;
                                state_next   = stat.last_evict ? ST_IDLE : ST_EVICT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EVICT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.op          = OP_EVICT;
                    cmd.out_load    = 1'b1;
                    cmd.res_kind    = RES_FREED;
                    cmd.res_success = (stat.mode == MODE_ENSURE);
                    cmd.res_last    = stat.last_evict;
                    ov_next         = 1'b1;
                    if (stat.last_evict)
                    begin
                        state_next = (stat.mode == MODE_ENSURE) ? ST_INSERT : ST_IDLE;
                    end
                end
            end
            ST_INSERT:
            begin
                cmd.op     = OP_INSERT;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/lru_residency_table.sv @@
// ---------------------------------------------------------------------------
// LRU residency table
// Fully associative tile table in least-recently-used order.
// ---------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tuser: mode; tdata: tile_key, sizes, upload_handle
// m_axis    out        tuser: freed_valid; tdata: success, handles; tlast
// cfg       in         enable, capacity_limit
//
// An item is accepted in idle and decided in the decide state, so a lookup, a
// hit, a refused ensure or a plain insert gives a single result. An ensure that
// evicts gives one result per eviction, then places the new entry. A clear
// gives one result per valid entry, or a single empty result if there is none.
// One output register holds a result; the next step waits while it is stalled,
// but a new item can be accepted behind it. Reset empties the table, clears
// enable and sets the limit to sixteen.
// ---------------------------------------------------------------------------
module lru_residency_table
    import lrt_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tile_key, tile_width, tile_height, channel_count, upload_handle
    input  logic [((KEY_BITS+33+HANDLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // success, handle_out, freed_handle
    output logic [((1+2*HANDLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // freed_valid
    output logic [0:0] m_axis_tuser,
    output logic m_axis_tlast,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [4:0] cfg_wdata
);

    localparam int OW = ((1 + 2 * HANDLE_BITS + 7) / 8) * 8;
    localparam int KO = 0;
    localparam int WO = KO + KEY_BITS;
    localparam int HO = WO + 15;
    localparam int CO = HO + 15;
    localparam int UO = CO + 3;

    logic       enable_reg;
    logic [4:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            limit_reg  <= 5'd16;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(REG_ENABLE))
            begin
                enable_reg <= cfg_wdata[0];
            end
            else
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    lrt_cmd_t               cmd;
    lrt_stat_t              stat;
    logic                   r_succ;
    logic [HANDLE_BITS-1:0] r_hnd;
    logic                   r_fv;
    logic [HANDLE_BITS-1:0] r_fh;
    logic                   r_last;
    logic                   ov;
    logic                   in_rdy;
    logic                   in_fire;

    assign in_fire = s_axis_tvalid && in_rdy;

    lrt_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .in_ready  (in_rdy),
        .out_valid (ov),
        .cmd       (cmd)
    );

    lrt_datapath #(
        .CAPACITY    (CAPACITY),
        .KEY_BITS    (KEY_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_mode          (s_axis_tuser),
        .in_key           (s_axis_tdata[WO-1:KO]),
        .in_width         (s_axis_tdata[HO-1:WO]),
        .in_height        (s_axis_tdata[CO-1:HO]),
        .in_channels      (s_axis_tdata[UO-1:CO]),
        .in_handle        (s_axis_tdata[UO+HANDLE_BITS-1:UO]),
        .enable           (enable_reg),
        .capacity_limit   (limit_reg),
        .cmd              (cmd),
        .stat             (stat),
        .res_success      (r_succ),
        .res_handle       (r_hnd),
        .res_freed_valid  (r_fv),
        .res_freed_handle (r_fh),
        .res_last         (r_last)
    );

    assign s_axis_tready = in_rdy;
    assign m_axis_tvalid = ov;
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = r_fv;
    assign m_axis_tdata  = OW'({r_fh, r_hnd, r_succ});

endmodule

@@ src/lrt_checker.sv @@
// ---------------------------------------------------------------------------
// LRU residency table checker
// Port-level properties of the input and result streams.
// ---------------------------------------------------------------------------
module lrt_checker
(
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
        else $error("last flag changed while stalled");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back to back accept");

endmodule

bind lru_residency_table lrt_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// LRU residency table testbench
// Drives ensure, lookup, clear and none items through the input stream, predicts
// every result from a local copy of the table and checks the output stream
// in order, across several enable and capacity limit settings.
// ---------------------------------------------------------------------------
module tb;
    import lrt_pkg::*;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        mode_t       mode;
        logic [31:0] key;
        logic [14:0] width;
        logic [14:0] height;
        logic [2:0]  channels;
        logic [31:0] handle;
        bit          drain_first;
    } tile_req_t;

    typedef struct {
        logic        success;
        logic [31:0] handle_out;
        logic        freed_valid;
        logic [31:0] freed_handle;
        logic        last;
    } tile_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [4:0]   cfg_wdata;

    tile_req_t   pending_reqs[$];
    tile_res_t   expected_res[$];
    tile_req_t   cur_req;
    logic [31:0] key_pool[24];

    logic [31:0] tbl_key[SLOTS];
    logic [31:0] tbl_handle[SLOTS];
    bit          tbl_valid[SLOTS];
    int          tbl_rank[SLOTS];
    int          tbl_count;
    bit          tbl_enable;
    int          tbl_limit;

    int  send_gap;
    int  recv_stall;
    bit  quiet;
    int  mismatches;
    int  cycles;
    int  items_sent;
    int  results_seen;
    int  freed_seen;

    lru_residency_table dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic void push_res(logic s, logic [31:0] h, logic fv, logic [31:0] fh);
        tile_res_t r;
        r.success = s;
        r.handle_out = h;
        r.freed_valid = fv;
        r.freed_handle = fh;
        r.last = 1'b0;
        expected_res.insert(expected_res.size(), r);
    endfunction

    function automatic int oldest_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && (best < 0 || tbl_rank[i] > tbl_rank[best]))
                best = i;
        return best;
    endfunction

    function automatic void predict_table(tile_req_t q);
        int n0;
        int hit;
        int lim;
        int need;
        int o;
        int free_slot;
        n0 = expected_res.size();
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == q.key)
                hit = i;
        case (q.mode)
            MODE_ENSURE:
            begin
                if (!tbl_enable)
                    push_res(1'b0, 32'd0, 1'b0, 32'd0);
                else if (hit >= 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_valid[i] && tbl_rank[i] < tbl_rank[hit])
                            tbl_rank[i]++;
                    tbl_rank[hit] = 0;
                    push_res(1'b1, tbl_handle[hit], 1'b0, 32'd0);
                end
                else if (q.width == 0 || q.height == 0 || q.channels == 0 || q.handle == 0)
                    push_res(1'b0, 32'd0, 1'b0, 32'd0);
                else
                begin
                    lim = tbl_limit < 1 ? 1 : (tbl_limit > SLOTS ? SLOTS : tbl_limit);
                    need = tbl_count + 1 > lim ? tbl_count + 1 - lim : 0;
                    for (int e = 0; e < need; e++)
                    begin
                        o = oldest_slot();
                        if (o >= 0)
                        begin
                            tbl_valid[o] = 0;
                            tbl_count--;
                            push_res(1'b1, q.handle, 1'b1, tbl_handle[o]);
                        end
                    end
                    free_slot = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!tbl_valid[i])
                            free_slot = i;
                    if (free_slot >= 0)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (tbl_valid[i])
                                tbl_rank[i]++;
                        tbl_valid[free_slot] = 1;
                        tbl_key[free_slot] = q.key;
                        tbl_handle[free_slot] = q.handle;
                        tbl_rank[free_slot] = 0;
                        tbl_count++;
                    end
                    if (expected_res.size() == n0)
                        push_res(1'b1, q.handle, 1'b0, 32'd0);
                end
            end
            MODE_LOOKUP:
            begin
                if (hit >= 0)
                    push_res(1'b1, tbl_handle[hit], 1'b0, 32'd0);
                else
                    push_res(1'b0, 32'd0, 1'b0, 32'd0);
            end
            MODE_CLEAR:
            begin
                o = oldest_slot();
                while (o >= 0)
                begin
                    tbl_valid[o] = 0;
                    push_res(1'b0, 32'd0, 1'b1, tbl_handle[o]);
                    o = oldest_slot();
                end
                for (int i = 0; i < SLOTS; i++)
                    tbl_rank[i] = 0;
                tbl_count = 0;
                if (expected_res.size() == n0)
                    push_res(1'b0, 32'd0, 1'b0, 32'd0);
            end
            default:
                push_res(1'b0, 32'd0, 1'b0, 32'd0);
        endcase
        expected_res[expected_res.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_table(cur_req);
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !(pending_reqs[0].drain_first
                         && (expected_res.size() > 0 || s_axis_tvalid)))
                begin
                    cur_req = pending_reqs[0];
                    pending_reqs.delete(0);
                    s_axis_tdata <= {7'b0, cur_req.handle, cur_req.channels, cur_req.height,
                                     cur_req.width, cur_req.key};
                    s_axis_tuser <= cur_req.mode;
                    s_axis_tvalid <= 1'b1;
                    send_gap <= draw_wait();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        tile_res_t want;
        int w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb: timeout after %0d cycles", cycles);
                $display("tb: FAIL");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tuser[0])
                    freed_seen++;
                if (expected_res.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: unexpected result %h fv %b last %b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    want = expected_res[0];
                    expected_res.delete(0);
                    if (m_axis_tdata[0] !== want.success || m_axis_tdata[32:1] !== want.handle_out
                        || m_axis_tuser[0] !== want.freed_valid
                        || m_axis_tdata[64:33] !== want.freed_handle
                        || m_axis_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("tb: mismatch expected s=%b h=%h fv=%b fh=%h l=%b",
                                     want.success, want.handle_out, want.freed_valid,
                                     want.freed_handle, want.last);
                            $display("tb:          actual   s=%b h=%h fv=%b fh=%h l=%b",
                                     m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tuser[0],
                                     m_axis_tdata[64:33], m_axis_tlast);
                        end
                    end
                end
                w = draw_wait();
                recv_stall <= w;
                m_axis_tready <= (w == 0);
            end
            else if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                m_axis_tready <= (recv_stall == 1);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic tile_req_t make_req(mode_t m, logic [31:0] k, logic [31:0] h);
        tile_req_t q;
        q.mode = m;
        q.key = k;
        q.width = 15'($urandom_range(1, 32767));
        q.height = 15'($urandom_range(1, 32767));
        q.channels = 3'($urandom_range(1, 7));
        q.handle = h;
        q.drain_first = 0;
        return q;
    endfunction

    function automatic tile_req_t random_req();
        tile_req_t q;
        int p;
        p = $urandom_range(0, 99);
        q = make_req(p < 62 ? MODE_ENSURE : p < 88 ? MODE_LOOKUP : p < 95 ? MODE_CLEAR : MODE_NONE,
                     $urandom_range(0, 9) == 0 ? $urandom : key_pool[$urandom_range(0, 23)],
                     $urandom_range(0, 15) == 0 ? 32'd0 : $urandom);
        case ($urandom_range(0, 19))
            0: q.width = 0;
            1: q.height = 0;
            2: q.channels = 0;
            3: q.channels = 3'($urandom);
            default: ;
        endcase
        return q;
    endfunction

    function automatic void queue_req(tile_req_t q);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_res.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int value);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= 1'(idx);
        cfg_wdata <= 5'(value);
        if (idx == REG_ENABLE)
            tbl_enable = value[0];
        else
            tbl_limit = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count, bit burst);
        tile_req_t q;
        quiet = burst;
        for (int i = 0; i < count; i++)
        begin
            q = random_req();
            q.drain_first = (i == count / 2);
            queue_req(q);
        end
    endtask

    initial
    begin
        tile_req_t q;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        quiet = 0;
        mismatches = 0;
        cycles = 0;
        items_sent = 0;
        results_seen = 0;
        freed_seen = 0;
        tbl_count = 0;
        tbl_enable = 0;
        tbl_limit = 16;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_valid[i] = 0;
            tbl_rank[i] = 0;
        end
        for (int i = 0; i < 24; i++)
            key_pool[i] = (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_req(make_req(MODE_ENSURE, key_pool[2], $urandom));
        queue_req(make_req(MODE_LOOKUP, key_pool[2], 0));
        queue_req(make_req(MODE_CLEAR, 0, 0));
        queue_req(make_req(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        write_reg(REG_ENABLE, 1);
        q = make_req(MODE_ENSURE, key_pool[0], 32'hFFFF_FFFF);
        q.width = 15'h7FFF;
        q.height = 15'h7FFF;
        q.channels = 3'd7;
        queue_req(q);
        q = make_req(MODE_ENSURE, key_pool[1], 32'd1);
        q.width = 15'd1;
        q.height = 15'd1;
        q.channels = 3'd1;
        queue_req(q);
        q = make_req(MODE_ENSURE, key_pool[3], 32'd5);
        q.width = 0;
        queue_req(q);
        q = make_req(MODE_ENSURE, key_pool[3], 32'd5);
        q.height = 0;
        queue_req(q);
        q = make_req(MODE_ENSURE, key_pool[3], 32'd5);
        q.channels = 0;
        queue_req(q);
        queue_req(make_req(MODE_ENSURE, key_pool[3], 32'd0));
        queue_req(make_req(MODE_ENSURE, key_pool[3], $urandom));
        queue_req(make_req(MODE_ENSURE, key_pool[0], $urandom));
        queue_req(make_req(MODE_LOOKUP, key_pool[1], 0));
        queue_req(make_req(MODE_LOOKUP, key_pool[4], 0));
        write_reg(REG_LIMIT, 2);
        queue_req(make_req(MODE_ENSURE, key_pool[5], $urandom));
        queue_req(make_req(MODE_ENSURE, key_pool[5], $urandom));
        write_reg(REG_ENABLE, 0);
        queue_req(make_req(MODE_ENSURE, key_pool[5], $urandom));
        write_reg(REG_ENABLE, 1);
        write_reg(REG_LIMIT, 16);
        for (int i = 6; i < 22; i++)
            queue_req(make_req(MODE_ENSURE, key_pool[i], $urandom));
        write_reg(REG_LIMIT, 3);
        queue_req(make_req(MODE_ENSURE, key_pool[22], $urandom));
        queue_req(make_req(MODE_CLEAR, 0, 0));

        random_phase(35, 0);
        write_reg(REG_LIMIT, 31);
        random_phase(35, 1);
        write_reg(REG_LIMIT, 0);
        random_phase(25, 0);
        write_reg(REG_LIMIT, 16);
        random_phase(35, 0);
        write_reg(REG_LIMIT, 4);
        random_phase(25, 0);
        write_reg(REG_ENABLE, 0);
        random_phase(12, 0);
        write_reg(REG_ENABLE, 1);
        write_reg(REG_LIMIT, 1);
        random_phase(20, 1);
        write_reg(REG_LIMIT, 8);
        random_phase(25, 0);
        wait_idle();

        $display("tb: %0d items sent, %0d results checked, %0d freed handles seen",
                 items_sent, results_seen, freed_seen);
        $display("tb: limits 0..31 and enable on and off covered, %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

@@ lru_residency_table.f @@
src/lrt_pkg.sv
src/lrt_datapath.sv
src/lrt_control.sv
src/lru_residency_table.sv
src/lrt_checker.sv
verif/tb.sv
